### design/c8_pkg.sv
// Package for the CHIP-8 instruction core: sizes, command codes, configuration indices, beat types.
// No dependencies.
package c8_pkg;
  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int ROW_AW      = $clog2(SCREEN_H);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam logic [11:0] ROM_START  = 12'h200;
  localparam logic [11:0] FONT_START = 12'h050;

  localparam logic [2:0] CMD_EXEC  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_MWR   = 3'd2;
  localparam logic [2:0] CMD_MRD   = 3'd3;
  localparam logic [2:0] CMD_ROWRD = 3'd4;

  localparam logic [1:0] CFG_VIP   = 2'd0;
  localparam logic [1:0] CFG_JMPVX = 2'd1;
  localparam logic [1:0] CFG_SHIFT = 2'd2;
  localparam logic [1:0] CFG_LSM   = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] address;
    logic [7:0]  write_byte;
    logic [15:0] key_pad;
    logic [7:0]  random_byte;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [11:0] program_counter;
    logic        halted;
    logic        display_changed;
    logic        sound_on;
    logic        waiting_key;
  } out_beat_t;
endpackage

### design/chip8_instruction_core.sv
// CHIP-8 instruction core: memory, framebuffer, registers and sequencer.
// Depends on c8_pkg.
//
// Usage: each input beat carries one command (execute, timer tick, memory
// write, memory read, framebuffer row read) and yields exactly one result
// beat with the read data and core status. The configuration channel sets
// quirk bits; the user is to write it only while the core is idle, which the core itself does not enforce.
// Tick, write, unused commands and execute on a halted core go straight
// to the result; memory and row reads pass through an address state and a
// capture state; a plain instruction takes two fetch reads, decode and
// result. Clear screen, sprite draw, register save, register load and BCD
// add states of their own, sequenced by the single-port main memory and
// the row memory.
// One item is in work at a time; the core takes no new beat until the
// result of the last one is written.
// After reset the core clears main memory and the framebuffer, one entry a
// cycle; no input beat is accepted during that pass.
// A finished result sits in the output register; the next input beat is
// taken while it waits. A stalled result holds until taken, and the core
// stops in its final state until the result register frees.
module chip8_instruction_core
  import c8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FETCH0, S_FETCH1, S_FETCH2, S_DECODE,
    S_MRD, S_ROWRD, S_DRAW_M, S_DRAW_R, S_DRAW_W, S_CLS,
    S_BCD, S_STORE, S_LOAD0, S_LOAD1, S_RET, S_DONE
  } state_t;

  state_t state_r;
  in_beat_t cur_r;
  out_beat_t res_r;
  logic res_v_r;

  // main memory
  logic [7:0] mem [MEM_BYTES];
  logic [MEM_AW-1:0] m_addr;
  logic [7:0] m_wdata, m_rdata;
  logic m_we;
  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wdata;
    m_rdata <= mem[m_addr];
  end

  // framebuffer rows
  logic [63:0] fb [SCREEN_H];
  logic [ROW_AW-1:0] f_addr;
  logic [63:0] f_wdata, f_rdata;
  logic f_we;
  always_ff @(posedge clk) begin
    if (f_we) fb[f_addr] <= f_wdata;
    f_rdata <= fb[f_addr];
  end

  logic [7:0] v_r [16];
  logic [11:0] stk_r [STACK_DEPTH];
  logic [15:0] i_r;
  logic [11:0] pc_r, here_r;
  logic [SP_W-1:0] sp_r;
  logic [7:0] dt_r, st_r;
  logic halt_r, draw_r, blk_r;
  logic [4:0] key_r;
  logic vip_r, jvx_r, shf_r;
  logic [1:0] lsm_r;
  logic [15:0] op_r;
  logic [MEM_AW:0] clr_r;
  logic [4:0] cnt_r;
  logic [7:0] hi_r;
  logic hit_r;
  logic [63:0] data_r;

  wire [3:0] ox = op_r[11:8];
  wire [3:0] oy = op_r[7:4];
  wire [3:0] on = op_r[3:0];
  wire [7:0] onn = op_r[7:0];
  wire [11:0] onnn = op_r[11:0];
  wire [7:0] vx = v_r[ox];
  wire [7:0] vy = v_r[oy];
  wire [5:0] xp = vx[5:0];
  wire [ROW_AW-1:0] yp = vy[ROW_AW-1:0];
  wire [ROW_AW:0] yy = {1'b0, yp} + {1'b0, cnt_r[ROW_AW-1:0]};
  wire [15:0] i_off = i_r + {11'd0, cnt_r};
  // sprite row placed on the screen, clipped at the right edge
  wire [71:0] spr_w = {m_rdata, 64'd0} >> xp;
  wire [63:0] spr = spr_w[71:8];

  // decimal digits of VX: compare for hundreds, reciprocal multiply for tens
  wire [1:0] bcd_h = (vx >= 8'd200) ? 2'd2 : (vx >= 8'd100) ? 2'd1 : 2'd0;
  wire [7:0] bcd_r = vx - ((vx >= 8'd200) ? 8'd200 : (vx >= 8'd100) ? 8'd100 : 8'd0);
  wire [14:0] bcd_p = {8'd0, bcd_r[6:0]} * 15'd205;
  wire [3:0] bcd_t = bcd_p[14:11];
  wire [7:0] bcd_o = bcd_r - {1'b0, bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  always_comb begin
    m_addr = i_off[MEM_AW-1:0];
    m_we = 1'b0;
    m_wdata = 8'd0;
    f_addr = yy[ROW_AW-1:0];
    f_we = 1'b0;
    f_wdata = 64'd0;
    case (state_r)
      S_CLR: begin
        m_addr = clr_r[MEM_AW-1:0]; m_we = 1'b1;
        f_addr = clr_r[ROW_AW-1:0]; f_we = 1'b1;
      end
      S_FETCH0: m_addr = pc_r[MEM_AW-1:0];
      S_FETCH1: m_addr = pc_r[MEM_AW-1:0] + MEM_AW'(1);
      S_MRD: m_addr = cur_r.address[MEM_AW-1:0];
      S_ROWRD: f_addr = cur_r.address[ROW_AW-1:0];
      S_DRAW_W: begin f_we = 1'b1; f_wdata = f_rdata ^ spr; end
      S_CLS: begin f_addr = cnt_r[ROW_AW-1:0]; f_we = 1'b1; end
      S_BCD: begin
        m_we = cnt_r < 5'd3;
        m_wdata = (cnt_r == 5'd0) ? {6'd0, bcd_h} :
                  (cnt_r == 5'd1) ? {4'd0, bcd_t} : bcd_o;
      end
      S_STORE: begin m_we = 1'b1; m_wdata = v_r[cnt_r[3:0]]; end
      default: ;
    endcase
    if (state_r == S_IDLE && in_valid && in_data.cmd == CMD_MWR) begin
      m_addr = in_data.address[MEM_AW-1:0];
      m_we = 1'b1;
      m_wdata = in_data.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; res_v_r <= 1'b0;
      i_r <= '0; pc_r <= ROM_START; sp_r <= '0; dt_r <= '0; st_r <= '0;
      halt_r <= 1'b0; draw_r <= 1'b1; blk_r <= 1'b0; key_r <= '0;
      vip_r <= 1'b0; jvx_r <= 1'b0; shf_r <= 1'b0; lsm_r <= '0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stk_r[k] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_VIP:   vip_r <= cfg_data[0];
          CFG_JMPVX: jvx_r <= cfg_data[0];
          CFG_SHIFT: shf_r <= cfg_data[0];
          CFG_LSM:   lsm_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!res_v_r || !out_stall)) res_v_r <= 1'b1;
      else if (res_v_r && !out_stall) res_v_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (MEM_AW+1)'(MEM_BYTES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          cur_r <= in_data;
          data_r <= '0;
          case (in_data.cmd)
            CMD_EXEC:  state_r <= halt_r ? S_DONE : S_FETCH0;
            CMD_TICK: begin
              if (dt_r != 0) dt_r <= dt_r - 1'b1;
              if (st_r != 0) st_r <= st_r - 1'b1;
              state_r <= S_DONE;
            end
            CMD_MRD:   state_r <= S_MRD;
            CMD_ROWRD: state_r <= S_ROWRD;
            default:   state_r <= S_DONE;
          endcase
        end
        S_MRD: state_r <= S_LOAD1;
        S_LOAD1: begin
          if (cur_r.cmd == CMD_MRD) begin
            data_r <= {56'd0, m_rdata};
            state_r <= S_DONE;
          end else begin
            v_r[cnt_r[3:0]] <= m_rdata;
            if (cnt_r[3:0] == ox) begin
              if (lsm_r == 2'd0) i_r <= i_r + {12'd0, ox} + 16'd1;
              else if (lsm_r == 2'd1) i_r <= i_r + {12'd0, ox};
              state_r <= S_DONE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              state_r <= S_LOAD0;
            end
          end
        end
        S_LOAD0: state_r <= S_LOAD1;
        S_ROWRD: state_r <= S_RET;
        S_RET: begin
          data_r <= f_rdata; draw_r <= 1'b0; state_r <= S_DONE;
        end
        S_FETCH0: begin here_r <= pc_r; state_r <= S_FETCH1; end
        S_FETCH1: begin hi_r <= m_rdata; state_r <= S_FETCH2; end
        S_FETCH2: begin op_r <= {hi_r, m_rdata}; state_r <= S_DECODE; end
        S_DECODE: begin
          logic [11:0] pn, pn2, tgt;
          logic [8:0] s9;
          logic [16:0] s17;
          pn = here_r + 12'd2;
          pn2 = here_r + 12'd4;
          pc_r <= pn;
          blk_r <= 1'b0;
          if ({op_r[15:12], op_r[7:0]} != 12'hF0A) key_r <= '0;
          cnt_r <= '0;
          hit_r <= 1'b0;
          state_r <= S_DONE;
          tgt = onnn + {4'd0, (jvx_r ? vx : v_r[0])};
          s9 = 9'd0;
          s17 = 17'd0;
          case (op_r[15:12])
            4'h0:
              if (op_r == 16'h00E0) begin draw_r <= 1'b1; state_r <= S_CLS; end
              else if (op_r == 16'h00EE) begin
                pc_r <= stk_r[sp_r - 1'b1]; sp_r <= sp_r - 1'b1;
              end else halt_r <= 1'b1;
            4'h1: begin pc_r <= onnn; if (onnn == here_r) halt_r <= 1'b1; end
            4'h2: begin stk_r[sp_r] <= pn; sp_r <= sp_r + 1'b1; pc_r <= onnn; end
            4'h3: if (vx == onn) pc_r <= pn2;
            4'h4: if (vx != onn) pc_r <= pn2;
            4'h5: if (vx == vy) pc_r <= pn2;
            4'h6: v_r[ox] <= onn;
            4'h7: v_r[ox] <= vx + onn;
            4'h8: case (on)
              4'h0: v_r[ox] <= vy;
              4'h1: begin v_r[ox] <= vx | vy; if (vip_r) v_r[15] <= 8'd0; end
              4'h2: begin v_r[ox] <= vx & vy; if (vip_r) v_r[15] <= 8'd0; end
              4'h3: begin v_r[ox] <= vx ^ vy; if (vip_r) v_r[15] <= 8'd0; end
              4'h4: begin
                s9 = {1'b0, vx} + {1'b0, vy};
                v_r[ox] <= s9[7:0]; v_r[15] <= {7'd0, s9[8]};
              end
              4'h5: begin v_r[ox] <= vx - vy; v_r[15] <= {7'd0, vx >= vy}; end
              4'h7: begin v_r[ox] <= vy - vx; v_r[15] <= {7'd0, vy >= vx}; end
              4'h6: begin
                v_r[ox] <= (shf_r ? vx : vy) >> 1;
                v_r[15] <= {7'd0, shf_r ? vx[0] : vy[0]};
              end
              4'hE: begin
                v_r[ox] <= (shf_r ? vx : vy) << 1;
                v_r[15] <= {7'd0, shf_r ? vx[7] : vy[7]};
              end
              default: halt_r <= 1'b1;
            endcase
            4'h9: if (vx != vy) pc_r <= pn2;
            4'hA: i_r <= {4'd0, onnn};
            4'hB: begin pc_r <= tgt; if (tgt == here_r) halt_r <= 1'b1; end
            4'hC: v_r[ox] <= cur_r.random_byte & onn;
            4'hD: begin
              draw_r <= 1'b1;
              if (on == 4'd0) v_r[15] <= 8'd0;
              else state_r <= S_DRAW_M;
            end
            4'hE:
              if (onn == 8'h9E) begin
                if (cur_r.key_pad[vx[3:0]]) pc_r <= pn2;
              end else if (onn == 8'hA1) begin
                if (!cur_r.key_pad[vx[3:0]]) pc_r <= pn2;
              end else halt_r <= 1'b1;
            default: case (onn)
              8'h07: v_r[ox] <= dt_r;
              8'h0A: begin
                if (!key_r[4]) begin
                  for (int k = 15; k >= 0; k--)
                    if (cur_r.key_pad[k]) key_r <= {1'b1, 4'(k)};
                  blk_r <= 1'b1; pc_r <= here_r;
                end else if (cur_r.key_pad[key_r[3:0]]) begin
                  blk_r <= 1'b1; pc_r <= here_r;
                end else begin
                  v_r[ox] <= {4'd0, key_r[3:0]}; key_r <= '0;
                end
              end
              8'h15: dt_r <= vx;
              8'h18: st_r <= vx;
              8'h1E: begin
                s17 = {1'b0, i_r} + {9'd0, vx};
                i_r <= s17[15:0];
                v_r[15] <= {7'd0, s17 > 17'h0FFF};
              end
              8'h29: i_r <= {4'd0, FONT_START + {6'd0, vx[3:0], 2'd0} + {8'd0, vx[3:0]}};
              8'h33: state_r <= S_BCD;
              8'h55: state_r <= S_STORE;
              8'h65: state_r <= S_LOAD0;
              default: halt_r <= 1'b1;
            endcase
          endcase
        end
        S_CLS: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[ROW_AW-1:0] == ROW_AW'(SCREEN_H - 1)) state_r <= S_DONE;
        end
        S_DRAW_M: begin
          if (yy >= (ROW_AW+1)'(SCREEN_H) || cnt_r[3:0] == on) begin
            v_r[15] <= {7'd0, hit_r};
            state_r <= S_DONE;
          end else state_r <= S_DRAW_R;
        end
        S_DRAW_R: state_r <= S_DRAW_W;
        S_DRAW_W: begin
          if ((f_rdata & spr) != 64'd0) hit_r <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
          state_r <= S_DRAW_M;
        end
        S_BCD: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd2) state_r <= S_DONE;
        end
        S_STORE: begin
          if (cnt_r[3:0] == ox) begin
            if (lsm_r == 2'd0) i_r <= i_r + {12'd0, ox} + 16'd1;
            else if (lsm_r == 2'd1) i_r <= i_r + {12'd0, ox};
            state_r <= S_DONE;
          end else cnt_r <= cnt_r + 1'b1;
        end
        // hold here until the result register frees
        S_DONE: if (!res_v_r || !out_stall) begin
          res_r.read_data <= data_r;
          res_r.program_counter <= pc_r;
          res_r.halted <= halt_r;
          res_r.display_changed <= draw_r;
          res_r.sound_on <= st_r != 8'd0;
          res_r.waiting_key <= blk_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result beat stays valid while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && out_stall) |=> res_v_r) else $error("result dropped");
  // no input beat is taken during the clearing pass
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall) else $error("accept during clear");
  // a halted core does not move its pc on any accepted beat
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && halt_r && in_valid && !in_stall) |=> $stable(pc_r))
    else $error("pc moved while halted");
endmodule
